// ----- design/grbw_pkg.sv -----
// ----------------------------------------------------------------------------
// grbw_pkg
// Shared types and constants of the glyph row to 4bpp writer.
// ----------------------------------------------------------------------------
`default_nettype none

package grbw_pkg;

	localparam logic [7:0] COL_OFFSET = 8'd37;

	localparam logic [7:0] CMD_COL_LO = 8'h00;
	localparam logic [7:0] CMD_COL_HI = 8'h10;
	localparam logic [7:0] CMD_ROW_LO = 8'h60;
	localparam logic [7:0] CMD_ROW_HI = 8'h70;
	localparam logic [7:0] PIX_EVEN   = 8'h80;
	localparam logic [7:0] PIX_ODD    = 8'h08;
	localparam logic [3:0] NIB_MASK   = 4'hf;

	localparam int CFG_IDX_W = 8;
	localparam logic [CFG_IDX_W-1:0] REG_GLYPH_COLUMN = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GLYPH_ROW    = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GLYPH_WIDTH  = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_GLYPH_HEIGHT = 8'd3;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);

	// work for one accepted font byte
	typedef struct packed {
		logic       has_cmd;
		logic [7:0] col;
		logic [7:0] rowv;
		logic [2:0] npairs;
		logic [7:0] pix;
	} grbw_desc_t;

endpackage

`default_nettype wire

// ----- design/grbw_front.sv -----
// ----------------------------------------------------------------------------
// grbw_front
// Accepts font bytes, tracks row position and builds one work descriptor.
// ----------------------------------------------------------------------------
`default_nettype none

module grbw_front import grbw_pkg::*; #(
	parameter int MAX_WIDTH = 160
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_valid,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [7:0]           cfg_data,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic [7:0]           in_byte,
	output logic                      push,
	output grbw_desc_t                push_desc,
	input  wire logic                 q_ready
);

	localparam logic [7:0] MAXW = 8'(MAX_WIDTH);

	logic [7:0] column_q, row_q, width_q, height_q;
	logic [7:0] row_cnt_q;
	logic [4:0] bir_q;

	logic [7:0] eff_w;
	logic [5:0] bytes_per_row;
	logic [7:0] base;
	logic [2:0] npairs;
	logic       accept;
	logic       row_end;
	logic [7:0] row_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q <= 8'd0;
			row_q    <= 8'd0;
			width_q  <= 8'd8;
			height_q <= 8'd8;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_GLYPH_COLUMN: column_q <= cfg_data;
				REG_GLYPH_ROW:    row_q    <= cfg_data;
				REG_GLYPH_WIDTH:  width_q  <= cfg_data;
				REG_GLYPH_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		eff_w = width_q;
		if (eff_w == 8'd0) eff_w = 8'd1;
		if (eff_w > MAXW)  eff_w = MAXW;
		bytes_per_row = 6'((9'(eff_w) + 9'd7) >> 3);
		base = {bir_q, 3'b000};
		npairs = 3'd0;
		for (int k = 0; k < 4; k++) begin
			if (9'(base) + 9'(2 * k + 1) < 9'(eff_w)) npairs = npairs + 3'd1;
		end
	end

	assign in_ready = q_ready;
	assign accept   = in_valid && in_ready;
	assign row_end  = (6'(bir_q) + 6'd1) >= bytes_per_row;
	assign row_next = row_cnt_q + 8'd1;

	// drop items that produce nothing
	assign push = accept && ((bir_q == 5'd0) || (npairs != 3'd0));

	always_comb begin
		push_desc.has_cmd = (bir_q == 5'd0);
		push_desc.col     = column_q + COL_OFFSET;
		push_desc.rowv    = row_q + row_cnt_q;
		push_desc.npairs  = npairs;
		push_desc.pix     = in_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_cnt_q <= 8'd0;
			bir_q     <= 5'd0;
		end else if (accept) begin
			if (row_end) begin
				bir_q     <= 5'd0;
				row_cnt_q <= (row_next == height_q) ? 8'd0 : row_next;
			end else begin
				bir_q <= bir_q + 5'd1;
			end
		end
	end

endmodule

`default_nettype wire

// ----- design/grbw_queue.sv -----
// ----------------------------------------------------------------------------
// grbw_queue
// Short descriptor queue between the front and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module grbw_queue import grbw_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	input  wire grbw_desc_t  push_desc,
	output logic             push_ready,
	input  wire logic        pop,
	output logic             head_valid,
	output grbw_desc_t       head_desc
);

	grbw_desc_t            entry_q [QDEPTH];
	logic [QPTR_W-1:0]     wr_ptr_q, rd_ptr_q;
	logic [QPTR_W:0]       count_q;

	assign push_ready = (count_q != (QPTR_W+1)'(QDEPTH));
	assign head_valid = (count_q != '0);
	assign head_desc  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push && push_ready) entry_q[wr_ptr_q] <= push_desc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push && push_ready) wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			if (pop && head_valid)  rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			case ({push && push_ready, pop && head_valid})
				2'b10:   count_q <= count_q + (QPTR_W+1)'(1);
				2'b01:   count_q <= count_q - (QPTR_W+1)'(1);
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- design/grbw_back.sv -----
// ----------------------------------------------------------------------------
// grbw_back
// Walks the head descriptor and sends one controller byte per cycle while the receiver is ready.
// ----------------------------------------------------------------------------
`default_nettype none

module grbw_back import grbw_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        head_valid,
	input  wire grbw_desc_t  head_desc,
	output logic             pop,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [7:0]       out_byte,
	output logic             out_is_data,
	output logic             out_last
);

	logic [2:0] idx_q;
	logic [2:0] last_idx;
	logic [1:0] pair;
	logic       is_cmd;
	logic [7:0] byte_nx;
	logic       advance;
	logic       at_end;

	assign last_idx = head_desc.has_cmd ? 3'd3 + head_desc.npairs
	                                    : head_desc.npairs - 3'd1;
	assign is_cmd   = head_desc.has_cmd && (idx_q < 3'd4);
	assign pair     = head_desc.has_cmd ? 2'(idx_q - 3'd4) : idx_q[1:0];
	assign at_end   = (idx_q == last_idx);
	assign advance  = head_valid && (!out_valid || out_ready);
	assign pop      = advance && at_end;

	always_comb begin
		byte_nx = 8'd0;
		if (is_cmd) begin
			case (idx_q[1:0])
				2'd0:    byte_nx = CMD_COL_LO | {4'd0, head_desc.col[3:0] & NIB_MASK};
				2'd1:    byte_nx = CMD_COL_HI | {4'd0, head_desc.col[7:4]};
				2'd2:    byte_nx = CMD_ROW_LO | {4'd0, head_desc.rowv[3:0] & NIB_MASK};
				default: byte_nx = CMD_ROW_HI | {4'd0, head_desc.rowv[7:4]};
			endcase
		end else begin
			if (head_desc.pix[{pair, 1'b0}]) byte_nx = byte_nx | PIX_EVEN;
			if (head_desc.pix[{pair, 1'b1}]) byte_nx = byte_nx | PIX_ODD;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q     <= 3'd0;
			out_valid <= 1'b0;
		end else begin
			if (advance) begin
				out_valid <= 1'b1;
				idx_q     <= at_end ? 3'd0 : idx_q + 3'd1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_byte    <= byte_nx;
			out_is_data <= !is_cmd;
			out_last    <= at_end;
		end
	end

endmodule

`default_nettype wire

// ----- design/glyph_row_bitmap_to_4bpp_writer.sv -----
// ----------------------------------------------------------------------------
// glyph_row_bitmap_to_4bpp_writer
// Turns 1bpp glyph bitmap bytes into address commands and 4bpp pixel bytes.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream (s_*) takes one glyph bitmap byte per request, rows in order,
//   ceil(width/8) bytes per row, pixel bits LSB first.
//   Master stream (m_*) sends controller bytes: tuser high marks pixel data,
//   low marks an address command; tlast marks the final byte of one request.
//   The configuration channel writes column, row, width and height by index
//   0..3; other indexes are ignored. Write only while the block is idle.
//   The first result of a request passes a queue entry, then the output register.
//   Throughput: one result per cycle while m_tready is high. A request
//   yields 0 to 8 output bytes: none when it yields no result, 4 for a full
//   interior byte, 8 for a full row-start byte.
//   A four-entry descriptor queue lets the input keep accepting while the
//   receiver stalls; once it fills, s_tready drops until results drain.
//   Reset clears the counters and registers to column 0, row 0, width 8 and
//   height 8, and empties the queue and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module glyph_row_bitmap_to_4bpp_writer import grbw_pkg::*; #(
	parameter int MAX_WIDTH = 160
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [7:0]           cfg_data,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	input  wire logic [7:0]           s_tdata,   // [7:0] font_byte
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	output logic [7:0]                m_tdata,   // [7:0] out_byte
	output logic                      m_tuser,   // [0] is_data
	output logic                      m_tlast
);

	logic       push, q_ready, pop, head_valid;
	grbw_desc_t push_desc, head_desc;

	assign cfg_ready = 1'b1;

	grbw_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_byte   (s_tdata),
		.push      (push),
		.push_desc (push_desc),
		.q_ready   (q_ready)
	);

	grbw_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_desc  (push_desc),
		.push_ready (q_ready),
		.pop        (pop),
		.head_valid (head_valid),
		.head_desc  (head_desc)
	);

	grbw_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_valid  (head_valid),
		.head_desc   (head_desc),
		.pop         (pop),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_byte    (m_tdata),
		.out_is_data (m_tuser),
		.out_last    (m_tlast)
	);

endmodule

`default_nettype wire

// ----- design/grbw_checker.sv -----
// ----------------------------------------------------------------------------
// grbw_checker
// Port-level checks of the glyph row writer output stream.
// ----------------------------------------------------------------------------
`default_nettype none

module grbw_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       m_tvalid,
	input wire logic       m_tready,
	input wire logic [7:0] m_tdata,
	input wire logic       m_tuser,
	input wire logic       m_tlast
);

	// hold a stalled result
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
		&& $stable(m_tlast))
		else $error("stalled output changed");

	a_pixel_format: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> (m_tdata[6:4] == 3'd0) && (m_tdata[2:0] == 3'd0))
		else $error("pixel byte has stray bits");

	a_cmd_opcode: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> (m_tdata[7:4] == 4'h0) || (m_tdata[7:4] == 4'h1)
		|| (m_tdata[7:4] == 4'h6) || (m_tdata[7:4] == 4'h7))
		else $error("unknown command byte");

	// a request that ends on a command ends on the row high nibble
	a_cmd_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser && m_tlast |-> (m_tdata[7:4] == 4'h7))
		else $error("command run ended early");

endmodule

bind glyph_row_bitmap_to_4bpp_writer grbw_checker u_grbw_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);

`default_nettype wire
